// ===== sv/devicetree_blob_token_parser_top_assert.svh =====
// Assertion macros shared by the devicetree blob parser RTL.
// Included by files that check their own logic; needs clock and reset in scope.
`ifndef DEVICETREE_BLOB_TOKEN_PARSER_TOP_ASSERT_SVH
`define DEVICETREE_BLOB_TOKEN_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define DTBP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define DTBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/dtbp_pkg.sv =====
// Shared constants and types for the devicetree blob token parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package dtbp_pkg;

   // Position width and header word indices.
   localparam int POS_W = 30;
   localparam logic [POS_W-1:0] HDR_STRUCT_OFF_IDX  = POS_W'(2);
   localparam logic [POS_W-1:0] HDR_STRUCT_SIZE_IDX = POS_W'(9);

   localparam logic [31:0] FDT_MAGIC = 32'hD00DFEED;

   // Structure block tokens.
   localparam logic [31:0] TK_BEGIN   = 32'd1;
   localparam logic [31:0] TK_ENDNODE = 32'd2;
   localparam logic [31:0] TK_PROP    = 32'd3;
   localparam logic [31:0] TK_NOP     = 32'd4;
   localparam logic [31:0] TK_END     = 32'd9;

   // Event codes reported on the result channel.
   localparam logic [3:0] EV_NONE     = 4'd0;
   localparam logic [3:0] EV_BEGIN    = 4'd1;
   localparam logic [3:0] EV_ENDNODE  = 4'd2;
   localparam logic [3:0] EV_PHDR     = 4'd3;
   localparam logic [3:0] EV_PDATA    = 4'd4;
   localparam logic [3:0] EV_NOP      = 4'd5;
   localparam logic [3:0] EV_END      = 4'd6;
   localparam logic [3:0] EV_BADMAGIC = 4'd7;
   localparam logic [3:0] EV_BADTOKEN = 4'd8;
   localparam logic [3:0] EV_NAME     = 4'd9;

   // Result port packing.
   localparam int RSP_DATA_W = 104;

   // One result item.
   typedef struct packed {
      logic [3:0]  event_res;
      logic [31:0] name_offset;
      logic [31:0] prop_length;
      logic [31:0] data_word;
      logic [2:0]  data_bytes;
      logic        last_data;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/devicetree_blob_token_parser_top.sv =====
// Devicetree blob token parser: takes a flattened devicetree blob one
// big-endian word per beat and reports the tokens of its structure block.
//
// Request channel: req_tdata carries the next four blob bytes, first byte in
// bits 31..24; req_tuser marks the header magic word and restarts the parse.
// Result channel: exactly one beat per request beat, in order. rsp_tuser is
// the event code, rsp_tlast marks the final value word of a property or the
// name word that holds the terminating zero byte.
// Path: a request beat accepted into the input register is loaded into the result
// register at the next edge where that register moves, and its result is then
// offered on the result channel.
// Throughput: one beat per cycle while the receiver keeps up; the parse state is
// decoded combinationally per word between the input and result registers.
// Stalls: with the result register held, the input register still takes one
// beat, after which req_tready drops until the receiver takes a result.
// Reset: both registers empty, parse idle until a header magic word arrives.
// Depends on dtbp_pkg, dtbp_core and dtbp_rsp_reg.
`default_nettype none
`include "devicetree_blob_token_parser_top_assert.svh"

module devicetree_blob_token_parser_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [31:0] blob_word
   input  wire logic [31:0]                       req_tdata,
   // [0] first_word
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [31:0] name_offset, [63:32] prop_length, [95:64] data_word,
   // [98:96] data_bytes, [103:99] zero
   output logic [dtbp_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // [3:0] event_res
   output logic [3:0]                             rsp_tuser,
   output logic                                   rsp_tlast
);
   import dtbp_pkg::*;

   logic        in_valid_ff;
   logic [31:0] in_word_ff;
   logic        in_first_ff;
   logic        advance;
   logic        step;
   rsp_type     res;

   // A held beat moves on whenever the result register can take it.
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_word_ff  <= req_tdata;
         in_first_ff <= req_tuser;
      end
   end

   dtbp_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .word  (in_word_ff),
      .first (in_first_ff),
      .res   (res)
   );

   dtbp_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .res        (res),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Every word passed to the parser turns up in the result register.
   `DTBP_ASSERT_NEXT(a_step_loads, step, rsp_tvalid, "parsed word did not reach the result register")
   // A held word is kept while the result side is blocked.
   `DTBP_ASSERT_NEXT(a_hold_input, in_valid_ff && !advance, in_valid_ff && $stable(in_word_ff), "held word lost during a stall")
   // A word never waits in the input register while the result register is free.
   `DTBP_ASSERT_NOW(a_no_bubble, in_valid_ff && !rsp_tvalid, step, "input word stuck with an empty result register")

endmodule

`default_nettype wire

// ===== sv/dtbp_core.sv =====
// Parse state and per-word decode of the devicetree blob parser.
// Depends on dtbp_pkg and the shared assertion macro header.
`default_nettype none
`include "devicetree_blob_token_parser_top_assert.svh"

module dtbp_core (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire logic [31:0]     word,
   input  wire logic            first,
   output dtbp_pkg::rsp_type    res
);
   import dtbp_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_HEADER,
      PH_SKIP,
      PH_TOKEN,
      PH_NAME,
      PH_PLEN,
      PH_POFF,
      PH_PDATA
   } phase_type;

   phase_type          phase_ff, phase_in, work_phase;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   start_ff, start_in;
   logic [31:0]        left_ff, left_in, left_dec;
   logic [31:0]        hlen_ff, hlen_in;
   logic [31:0]        hoff_ff, hoff_in;
   logic [31:0]        dleft_ff, dleft_in;
   logic [2:0]         dbytes;

   function automatic logic any_zero_byte(input logic [31:0] w);
      any_zero_byte = (w[31:24] == 8'd0) || (w[23:16] == 8'd0) ||
                      (w[15:8] == 8'd0) || (w[7:0] == 8'd0);
   endfunction

   // Structure byte count drops by one word, saturating at zero.
   assign left_dec = (left_ff >= 32'd4) ? (left_ff - 32'd4) : 32'd0;
   // Bytes of the property value carried by this word.
   assign dbytes   = (dleft_ff >= 32'd4) ? 3'd4 : dleft_ff[2:0];
   // A skipping parse enters the structure block on the word at its offset.
   assign work_phase = ((phase_ff == PH_SKIP) && (pos_ff >= start_ff)) ? PH_TOKEN
                                                                        : phase_ff;

   // Next state and result for the word in the input register.
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      left_in  = left_ff;
      hlen_in  = hlen_ff;
      hoff_in  = hoff_ff;
      dleft_in = dleft_ff;
      res      = '0;
      res.event_res = EV_NONE;

      if (first) begin
         // A header magic word restarts everything.
         pos_in   = '0;
         start_in = '0;
         left_in  = '0;
         hlen_in  = '0;
         hoff_in  = '0;
         dleft_in = '0;
         if (word == FDT_MAGIC) begin
            phase_in = PH_HEADER;
            pos_in   = POS_W'(1);
         end else begin
            phase_in = PH_IDLE;
            res.event_res = EV_BADMAGIC;
         end
      end else if (phase_ff != PH_IDLE) begin
         if (pos_ff != '1) begin
            pos_in = pos_ff + POS_W'(1);
         end
         if (phase_ff == PH_HEADER) begin
            if (pos_ff == HDR_STRUCT_OFF_IDX) begin
               start_in = word[31:2];
            end
            if (pos_ff == HDR_STRUCT_SIZE_IDX) begin
               left_in  = word;
               phase_in = PH_SKIP;
            end
         end else begin
            case (work_phase)
               PH_TOKEN: begin
                  if (left_ff == 32'd0) begin
                     phase_in = PH_IDLE;
                  end else begin
                     left_in  = left_dec;
                     phase_in = PH_TOKEN;
                     case (word)
                        TK_BEGIN: begin
                           res.event_res = EV_BEGIN;
                           phase_in = PH_NAME;
                        end
                        TK_ENDNODE: res.event_res = EV_ENDNODE;
                        TK_PROP:    phase_in = PH_PLEN;
                        TK_NOP:     res.event_res = EV_NOP;
                        TK_END: begin
                           res.event_res = EV_END;
                           phase_in = PH_IDLE;
                        end
                        default: begin
                           res.event_res = EV_BADTOKEN;
                           phase_in = PH_IDLE;
                        end
                     endcase
                  end
               end
               PH_NAME: begin
                  left_in        = left_dec;
                  res.event_res  = EV_NAME;
                  res.data_word  = word;
                  res.data_bytes = 3'd4;
                  if (any_zero_byte(word)) begin
                     res.last_data = 1'b1;
                     phase_in = PH_TOKEN;
                  end
               end
               PH_PLEN: begin
                  left_in  = left_dec;
                  hlen_in  = word;
                  phase_in = PH_POFF;
               end
               PH_POFF: begin
                  left_in         = left_dec;
                  hoff_in         = word;
                  dleft_in        = hlen_ff;
                  res.event_res   = EV_PHDR;
                  res.name_offset = word;
                  res.prop_length = hlen_ff;
                  phase_in = (hlen_ff != 32'd0) ? PH_PDATA : PH_TOKEN;
               end
               PH_PDATA: begin
                  left_in         = left_dec;
                  dleft_in        = dleft_ff - {29'd0, dbytes};
                  res.event_res   = EV_PDATA;
                  res.name_offset = hoff_ff;
                  res.prop_length = hlen_ff;
                  res.data_word   = word;
                  res.data_bytes  = dbytes;
                  if (dleft_ff <= 32'd4) begin
                     res.last_data = 1'b1;
                     phase_in = PH_TOKEN;
                  end
               end
               default: begin
                  // Still short of the structure block.
               end
            endcase
         end
      end
   end

   // Parse state, updated once per word that moves to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         left_ff  <= '0;
         hlen_ff  <= '0;
         hoff_ff  <= '0;
         dleft_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         left_ff  <= left_in;
         hlen_ff  <= hlen_in;
         hoff_ff  <= hoff_in;
         dleft_ff <= dleft_in;
      end
   end

   // The final value word of a property hands back to token parsing.
   `DTBP_ASSERT_NEXT(a_pdata_done, step && !first && phase_ff == PH_PDATA && dleft_ff <= 32'd4, phase_ff == PH_TOKEN, "property data did not end on its last word")
   // Only name and value words carry a last marker.
   `DTBP_ASSERT_NOW(a_last_kind, res.last_data, res.event_res == EV_PDATA || res.event_res == EV_NAME, "last marker on an event without data")
   // Byte counts appear only with data-carrying events.
   `DTBP_ASSERT_NOW(a_bytes_kind, res.event_res != EV_PDATA && res.event_res != EV_NAME, res.data_bytes == 3'd0, "byte count on an event without data")
   // Inside a property value there is always data left to take.
   `DTBP_ASSERT_NOW(a_pdata_left, phase_ff == PH_PDATA, dleft_ff != 32'd0, "property data phase with nothing left")

endmodule

`default_nettype wire

// ===== sv/dtbp_rsp_reg.sv =====
// Result register of the devicetree blob parser: holds one beat for the
// result channel and packs its fields. Depends on dtbp_pkg.
`default_nettype none

module dtbp_rsp_reg (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              load_valid,
   input  wire dtbp_pkg::rsp_type                 res,
   output logic                                   advance,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [31:0] name_offset, [63:32] prop_length, [95:64] data_word,
   // [98:96] data_bytes, [103:99] zero
   output logic [dtbp_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // [3:0] event_res
   output logic [3:0]                             rsp_tuser,
   output logic                                   rsp_tlast
);
   import dtbp_pkg::*;

   logic    valid_ff;
   rsp_type res_ff;

   // The register takes a new beat when empty or being emptied.
   assign advance = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res;
      end
   end

   // Port packing.
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, res_ff.data_bytes, res_ff.data_word,
                        res_ff.prop_length, res_ff.name_offset};
   assign rsp_tuser  = res_ff.event_res;
   assign rsp_tlast  = res_ff.last_data;

endmodule

`default_nettype wire
